### rtl/split_flap_minutes_driver_macros.svh
// Assertion macros for the split-flap minutes driver checker.
`ifndef SPLIT_FLAP_MINUTES_DRIVER_MACROS_SVH
`define SPLIT_FLAP_MINUTES_DRIVER_MACROS_SVH

// Check a property on every edge outside reset.
`define SFMD_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sfmd check failed");

// Check a property on every edge, reset included.
`define SFMD_CHECK_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sfmd check failed");

`endif

### rtl/sfmd_pkg.sv
package sfmd_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_MINUTE = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;

  localparam logic [1:0] REG_STEPS_PER_FLAP = 2'd0;
  localparam logic [1:0] REG_ONES_LIMIT     = 2'd1;
  localparam logic [1:0] REG_TENS_LIMIT     = 2'd2;

  localparam logic [7:0] STEPS_PER_FLAP_RST = 8'd52;
  localparam logic [3:0] ONES_LIMIT_RST     = 4'd10;
  localparam logic [3:0] TENS_LIMIT_RST     = 4'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic       hall_ones;
    logic       hall_tens;
    logic [3:0] target_ones;
    logic [3:0] target_tens;
  } cmd_t;

  typedef struct packed {
    logic [3:0] coils_ones;
    logic [3:0] coils_tens;
    logic       busy_res;
    logic       rejected;
    logic [3:0] ones_digit;
    logic [3:0] tens_digit;
  } res_t;

  // Per-motor control for one processed item.
  typedef struct packed {
    logic tick;
    logic hall;
    logic load_home;
    logic load_steps;
  } motor_ctl_t;

  // Per-motor status back to the controller.
  typedef struct packed {
    logic [3:0] coil;
    logic       busy;
    logic       busy_next;
  } motor_sts_t;

endpackage

### rtl/split_flap_minutes_driver.sv
// An accepted item is held in the input register, then moves to the result register.
// Throughput: one item per cycle unless res_stall holds it; state is updated as the item
// moves from input to result register, so the next item sees it at once.
// Reset (rst, synchronous, active high) clears both motors and digits, empties
// both registers and loads steps_per_flap 52, ones_limit 10, tens_limit 6.
module split_flap_minutes_driver #(
  parameter int STEP_COUNT_BITS = 12
) (
  input  logic            clk,
  input  logic            rst,
  // command channel
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  sfmd_pkg::cmd_t  cmd,
  // result channel
  output logic            res_valid,
  input  logic            res_stall,
  output sfmd_pkg::res_t  res,
  // register writes
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data
);
  import sfmd_pkg::*;

  localparam int PROD_BITS = 12;
  localparam int EXT_BITS  = (STEP_COUNT_BITS > PROD_BITS) ? STEP_COUNT_BITS : PROD_BITS;
  localparam logic [EXT_BITS-1:0] STEP_MAX = EXT_BITS'({STEP_COUNT_BITS{1'b1}});

  // Steps for a number of flaps, saturated at the counter's top value.
  function automatic logic [STEP_COUNT_BITS-1:0] flap_steps(input logic [3:0] digits,
                                                            input logic [7:0] spf);
    logic [PROD_BITS-1:0] prod;
    logic [EXT_BITS-1:0]  prod_ext;
    prod     = PROD_BITS'(digits) * PROD_BITS'(spf);
    prod_ext = EXT_BITS'(prod);
    if (prod_ext > STEP_MAX) begin
      prod_ext = STEP_MAX;
    end
    return prod_ext[STEP_COUNT_BITS-1:0];
  endfunction

  // Clamp a set target below its limit; a zero limit clamps to zero.
  function automatic logic [3:0] clamp_target(input logic [3:0] t, input logic [3:0] limit);
    logic [3:0] r;
    r = t;
    if (limit == 4'd0) begin
      r = 4'd0;
    end else if (t >= limit) begin
      r = limit - 4'd1;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [7:0] steps_per_flap;
  logic [3:0] ones_limit;
  logic [3:0] tens_limit;

  // Input register, digit counters.
  cmd_t       item;
  logic       item_valid;
  logic [3:0] ones_count, ones_count_next;
  logic [3:0] tens_count, tens_count_next;

  // Datapath between input and result register.
  logic                       advance;
  logic                       busy_now;
  logic                       rejected;
  logic [3:0]                 set_ones, set_tens;
  logic [STEP_COUNT_BITS-1:0] ones_load, tens_load, one_flap;
  motor_ctl_t                 ones_ctl, tens_ctl;
  motor_sts_t                 ones_sts, tens_sts;
  res_t                       res_next;

  // Register writes are taken whenever offered; software must write only while idle, not enforced here.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_flap <= STEPS_PER_FLAP_RST;
      ones_limit     <= ONES_LIMIT_RST;
      tens_limit     <= TENS_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEPS_PER_FLAP: steps_per_flap <= cfg_data;
        REG_ONES_LIMIT:     ones_limit     <= cfg_data[3:0];
        REG_TENS_LIMIT:     tens_limit     <= cfg_data[3:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // The input item moves on when the result register is empty or is being drained.
  assign advance   = item_valid && (!res_valid || !res_stall);
  assign cmd_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  // Payload register: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      item <= cmd;
    end
  end

  assign busy_now = ones_sts.busy || tens_sts.busy;
  assign set_ones = clamp_target(item.target_ones, ones_limit);
  assign set_tens = clamp_target(item.target_tens, tens_limit);
  assign one_flap = flap_steps(4'd1, steps_per_flap);

  // Decode the item into motor controls and digit updates. Nothing is applied
  // unless the item advances this cycle.
  always_comb begin
    ones_ctl        = '0;
    tens_ctl        = '0;
    ones_ctl.hall   = item.hall_ones;
    tens_ctl.hall   = item.hall_tens;
    ones_load       = one_flap;
    tens_load       = one_flap;
    ones_count_next = ones_count;
    tens_count_next = tens_count;
    rejected        = 1'b0;
    if (advance) begin
      unique case (item.opcode)
        OP_TICK: begin
          ones_ctl.tick = 1'b1;
          tens_ctl.tick = 1'b1;
        end
        OP_MINUTE: begin
          if (busy_now) begin
            rejected = 1'b1;
          end else if ({1'b0, ones_count} + 5'd1 >= {1'b0, ones_limit}) begin
            // ones wrap: home the ones drum, carry into tens
            ones_count_next    = 4'd0;
            ones_ctl.load_home = 1'b1;
            if ({1'b0, tens_count} + 5'd1 >= {1'b0, tens_limit}) begin
              tens_count_next    = 4'd0;
              tens_ctl.load_home = 1'b1;
            end else begin
              tens_count_next     = tens_count + 4'd1;
              tens_ctl.load_steps = 1'b1;
            end
          end else begin
            ones_count_next     = ones_count + 4'd1;
            ones_ctl.load_steps = 1'b1;
          end
        end
        OP_SET: begin
          if (busy_now) begin
            rejected = 1'b1;
          end else begin
            // home both drums, then step out to the clamped targets
            ones_count_next     = set_ones;
            tens_count_next     = set_tens;
            ones_ctl.load_home  = 1'b1;
            ones_ctl.load_steps = 1'b1;
            tens_ctl.load_home  = 1'b1;
            tens_ctl.load_steps = 1'b1;
            ones_load           = flap_steps(set_ones, steps_per_flap);
            tens_load           = flap_steps(set_tens, steps_per_flap);
          end
        end
        default: ;  // unused opcode: ignore
      endcase
    end
  end

  sfmd_motor #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_ones (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ones_ctl),
    .load_value (ones_load),
    .sts        (ones_sts)
  );

  sfmd_motor #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_tens (
    .clk        (clk),
    .rst        (rst),
    .ctl        (tens_ctl),
    .load_value (tens_load),
    .sts        (tens_sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_count <= 4'd0;
      tens_count <= 4'd0;
    end else begin
      ones_count <= ones_count_next;
      tens_count <= tens_count_next;
    end
  end

  always_comb begin
    res_next.coils_ones = ones_sts.coil;
    res_next.coils_tens = tens_sts.coil;
    res_next.busy_res   = ones_sts.busy_next || tens_sts.busy_next;
    res_next.rejected   = rejected;
    res_next.ones_digit = ones_count_next;
    res_next.tens_digit = tens_count_next;
  end

  // Result register: fill on advance, empty once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

### rtl/sfmd_motor.sv
module sfmd_motor #(
  parameter int STEP_COUNT_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sfmd_pkg::motor_ctl_t       ctl,
  input  logic [STEP_COUNT_BITS-1:0] load_value,
  output sfmd_pkg::motor_sts_t       sts
);
  import sfmd_pkg::*;

  logic [1:0]                 phase, phase_next;
  logic [STEP_COUNT_BITS-1:0] steps_left, steps_left_next;
  logic                       homing, homing_next;
  logic [3:0]                 coil;

  always_comb begin
    phase_next      = phase;
    steps_left_next = steps_left;
    homing_next     = homing;
    coil            = 4'd0;
    if (ctl.tick) begin
      priority if (homing) begin
        // stop on the first phase-0 tick that sees the sensor low
        if (phase == 2'd0 && !ctl.hall) begin
          homing_next = 1'b0;
        end else begin
          coil       = 4'd1 << phase;
          phase_next = phase + 2'd1;
        end
      end else if (steps_left != '0) begin
        steps_left_next = steps_left - STEP_COUNT_BITS'(1);
        coil            = 4'd1 << phase;
        phase_next      = phase + 2'd1;
      end else begin
        // idle motor: leave the coils off
        coil = 4'd0;
      end
    end else begin
      if (ctl.load_home) begin
        homing_next = 1'b1;
      end
      if (ctl.load_steps) begin
        steps_left_next = load_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= 2'd0;
      steps_left <= '0;
      homing     <= 1'b0;
    end else begin
      phase      <= phase_next;
      steps_left <= steps_left_next;
      homing     <= homing_next;
    end
  end

  assign sts.coil      = coil;
  assign sts.busy      = homing || (steps_left != '0);
  assign sts.busy_next = homing_next || (steps_left_next != '0);

endmodule

### rtl/sfmd_checker.sv
`include "split_flap_minutes_driver_macros.svh"

module sfmd_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input sfmd_pkg::res_t res
);
  import sfmd_pkg::*;

  // reset empties the result register
  `SFMD_CHECK_ALWAYS(a_reset_empty, rst |=> !res_valid)
  // a stalled result item holds
  `SFMD_CHECK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res))
  // wave drive energizes at most one coil per motor
  `SFMD_CHECK(a_wave, res_valid |-> $onehot0(res.coils_ones) && $onehot0(res.coils_tens))
  // a rejected command drives no coil
  `SFMD_CHECK(a_rej_quiet, res_valid && res.rejected |-> {res.coils_ones, res.coils_tens} == 8'd0)
  // a rejection only happens while a motor is busy (rejection changes nothing, so busy_res still shows it)
  `SFMD_CHECK(a_rej_busy, res_valid && res.rejected |-> res.busy_res)

endmodule

bind split_flap_minutes_driver sfmd_checker u_sfmd_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
